/* hdl/cmmw_pkg.sv */
// Package for the codon MinMax window block: op codes, defaults and widths.
// Used by cmmw_if.sv and codon_minmax_window_top.sv.
package cmmw_pkg;
   // Input opcodes
   localparam logic [1:0] OP_LOAD_CODON = 2'd0;
   localparam logic [1:0] OP_LOAD_AA    = 2'd1;
   localparam logic [1:0] OP_STREAM     = 2'd2;
   localparam logic [1:0] OP_RESERVED   = 2'd3;

   // Parameter defaults
   localparam int WINDOW_CODONS_DEF = 17;
   localparam int FREQ_BITS_DEF     = 16;
   localparam int CODON_ENTRIES_DEF = 64;
   localparam int AA_ENTRIES_DEF    = 32;

   // Fixed field widths
   localparam int OP_W    = 2;
   localparam int INDEX_W = 6;
   localparam int CLASS_W = 5;
   localparam int FIELD_W = 16;
   localparam int SCORE_W = 16;

   // 2 * 100 * 256: doubled scale for round-to-nearest
   localparam int SCALE_X2 = 51200;
   localparam int SCALE_X2_W = 16;
endpackage

/* hdl/cmmw_if.sv */
// Valid/ready channel interfaces for the codon MinMax window block.
// Depends on cmmw_pkg.
interface cmmw_req_if;
   logic                          valid;
   logic                          ready;
   logic [cmmw_pkg::OP_W-1:0]     op;
   logic [cmmw_pkg::INDEX_W-1:0]  index;
   logic [cmmw_pkg::CLASS_W-1:0]  amino_acid;
   logic [cmmw_pkg::FIELD_W-1:0]  codon_frequency;
   logic [cmmw_pkg::FIELD_W-1:0]  aa_minimum;
   logic [cmmw_pkg::FIELD_W-1:0]  aa_maximum;
   logic [cmmw_pkg::FIELD_W-1:0]  aa_average;
   logic                          sequence_start;

   modport source (output valid, op, index, amino_acid, codon_frequency, aa_minimum,
                   aa_maximum, aa_average, sequence_start, input ready);
   modport sink   (input valid, op, index, amino_acid, codon_frequency, aa_minimum,
                   aa_maximum, aa_average, sequence_start, output ready);
endinterface

interface cmmw_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [cmmw_pkg::SCORE_W-1:0] percent_minmax;
   logic                                used_min_branch;
   logic                                divide_fault;

   modport source (output valid, percent_minmax, used_min_branch, divide_fault,
                   input ready);
   modport sink   (input valid, percent_minmax, used_min_branch, divide_fault,
                   output ready);
endinterface

/* hdl/codon_minmax_window_top.sv */
// Percent-MinMax codon rarity over a sliding window, top level.
// Depends on cmmw_pkg and the channel interfaces in cmmw_if.sv.
//
// Usage:
//  req_chan carries one beat per item. Op 0 loads a codon table entry
//  (class and frequency), op 1 loads an amino-acid entry (min, max, average),
//  op 2 streams a codon; sequence_start on op 2 empties the window first.
//  Table loads give no result.
//  Once WINDOW_CODONS codons have entered, every op 2 beat gives one rsp_chan
//  beat with the score in 1/256 percent, the branch used and a zero-divisor
//  flag. A streamed codon passes through the pipelined sweep of the ring and
//  table memories (sums are rebuilt from the current tables), the branch pick
//  and scaling, the bit-serial restoring divider and the output register load;
//  a zero divisor skips the scaling and the divider. The next item is taken once
//  the result is in the output register. A codon before the window is full
//  gives no result and leaves the block ready for the next item. One item is
//  in flight at a time. Reset empties the window; tables hold unknown data
//  until loaded. A finished result waits in the output register; the next item
//  is accepted meanwhile, and a later result waits until the stalled one is
//  taken.
module codon_minmax_window_top #(
   parameter int WINDOW_CODONS = cmmw_pkg::WINDOW_CODONS_DEF,
   parameter int FREQ_BITS     = cmmw_pkg::FREQ_BITS_DEF,
   parameter int CODON_ENTRIES = cmmw_pkg::CODON_ENTRIES_DEF,
   parameter int AA_ENTRIES    = cmmw_pkg::AA_ENTRIES_DEF
) (
   input logic      clock,
   input logic      reset,
   cmmw_req_if.sink req_chan,
   cmmw_rsp_if.source rsp_chan
);
   localparam int RB  = (WINDOW_CODONS > 1) ? $clog2(WINDOW_CODONS) : 1;
   localparam int FB  = $clog2(WINDOW_CODONS + 1);
   localparam int SB  = FREQ_BITS + FB;
   localparam int NB  = SB + 17;
   localparam int RW  = SB + 2;
   localparam int CB  = $clog2(NB + 1);
   localparam int CA  = $clog2(CODON_ENTRIES);
   localparam int AB  = $clog2(AA_ENTRIES);
   localparam int CW  = cmmw_pkg::CLASS_W;
   localparam int SW  = cmmw_pkg::SCORE_W;

   typedef enum logic [2:0] {S_IDLE, S_SWEEP, S_PICK, S_MULT, S_DIV, S_DONE} state_type;

   // Memories
   logic [cmmw_pkg::INDEX_W-1:0]  ring_mem [WINDOW_CODONS];
   logic [CW+FREQ_BITS-1:0]       codon_mem [CODON_ENTRIES];
   logic [3*FREQ_BITS-1:0]        aa_mem [AA_ENTRIES];

   state_type               state_ff;
   logic [RB-1:0]           ptr_ff;
   logic [FB-1:0]           fill_ff;
   logic [FB-1:0]           issue_ff;
   logic                    v1_ff, v2_ff, v3_ff;
   logic [cmmw_pkg::INDEX_W-1:0] ring_q_ff;
   logic [CW+FREQ_BITS-1:0] codon_q_ff;
   logic [3*FREQ_BITS-1:0]  aa_q_ff;
   logic [FREQ_BITS-1:0]    freq3_ff;
   logic                    aaok3_ff;
   logic [SB-1:0]           smin_ff, smax_ff, savg_ff, sact_ff;
   logic [SB-1:0]           an_ff, ad_ff;
   logic                    neg_ff, usemin_ff, fault_ff;
   logic [NB-1:0]           quo_ff;
   logic [RW-1:0]           rem_ff, den_ff;
   logic [CB-1:0]           cnt_ff;
   logic                    rv_ff, rmin_ff, rfault_ff;
   logic signed [SW-1:0]    rscore_ff;

   logic accept;
   logic [FB-1:0] fill_in;
   logic [RB-1:0] ptr_in, wr_ptr;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept = req_chan.valid && req_chan.ready;

   // Ring position and fill after a streamed codon
   always_comb begin
      wr_ptr = req_chan.sequence_start ? '0 : ptr_ff;
      ptr_in = (wr_ptr == RB'(WINDOW_CODONS - 1)) ? '0 : wr_ptr + 1'b1;
      fill_in = req_chan.sequence_start ? FB'(1) :
                (fill_ff == FB'(WINDOW_CODONS)) ? fill_ff : fill_ff + 1'b1;
   end

   // Branch selection on the window sums
   logic signed [SB:0] num, dmax, dmin, dsel;
   logic               use_min;
   always_comb begin
      num  = $signed({1'b0, sact_ff}) - $signed({1'b0, savg_ff});
      dmax = $signed({1'b0, smax_ff}) - $signed({1'b0, savg_ff});
      dmin = $signed({1'b0, savg_ff}) - $signed({1'b0, smin_ff});
      use_min = (num < 0 && dmax >= 0) || (num > 0 && dmax < 0);
      dsel = use_min ? dmin : dmax;
   end

   // Divider step
   logic [RW-1:0] rem_sh;
   logic          ge;
   always_comb begin
      rem_sh = {rem_ff[RW-2:0], quo_ff[NB-1]};
      ge = rem_sh >= den_ff;
   end

   // Saturate the rounded quotient
   logic signed [SW-1:0] score_sat;
   always_comb begin
      if (neg_ff)
         score_sat = (quo_ff > NB'(32768)) ? SW'(-32768) : SW'(-quo_ff);
      else
         score_sat = (quo_ff > NB'(32767)) ? SW'(32767) : SW'(quo_ff);
   end

   logic rsp_free;
   assign rsp_free = !rv_ff || rsp_chan.ready;

   // Sweep issue and output register load
   logic issue_go, rsp_load;
   assign issue_go = (state_ff == S_SWEEP) && (issue_ff != FB'(WINDOW_CODONS));
   assign rsp_load = (state_ff == S_DONE) && rsp_free;

   // Memory writes
   always_ff @(posedge clock) begin
      if (accept) begin
         case (req_chan.op)
            cmmw_pkg::OP_LOAD_CODON:
               codon_mem[req_chan.index[CA-1:0]] <=
                  {req_chan.amino_acid, FREQ_BITS'(req_chan.codon_frequency)};
            cmmw_pkg::OP_LOAD_AA:
               if (7'(req_chan.index) < 7'(AA_ENTRIES))
                  aa_mem[req_chan.index[AB-1:0]] <= {FREQ_BITS'(req_chan.aa_minimum),
                     FREQ_BITS'(req_chan.aa_maximum), FREQ_BITS'(req_chan.aa_average)};
            cmmw_pkg::OP_STREAM:
               ring_mem[wr_ptr] <= req_chan.index;
            default: ;
         endcase
      end
   end

   // Sweep pipeline: ring read, codon table read, amino-acid table read
   always_ff @(posedge clock) begin
      ring_q_ff  <= ring_mem[issue_ff[RB-1:0]];
      codon_q_ff <= codon_mem[ring_q_ff[CA-1:0]];
      aa_q_ff    <= aa_mem[codon_q_ff[FREQ_BITS +: AB]];
      freq3_ff   <= codon_q_ff[FREQ_BITS-1:0];
      aaok3_ff   <= 6'(codon_q_ff[CW+FREQ_BITS-1 -: CW]) < 6'(AA_ENTRIES);
   end

   // Control, sums, divider and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ptr_ff   <= '0;
         fill_ff  <= '0;
         issue_ff <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         rv_ff <= rsp_load || (rv_ff && !rsp_chan.ready);
         v1_ff <= issue_go;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         if (v3_ff) begin
            sact_ff <= sact_ff + SB'(freq3_ff);
            if (aaok3_ff) begin
               smin_ff <= smin_ff + SB'(aa_q_ff[3*FREQ_BITS-1 -: FREQ_BITS]);
               smax_ff <= smax_ff + SB'(aa_q_ff[2*FREQ_BITS-1 -: FREQ_BITS]);
               savg_ff <= savg_ff + SB'(aa_q_ff[FREQ_BITS-1:0]);
            end
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept && req_chan.op == cmmw_pkg::OP_STREAM) begin
                  ptr_ff  <= ptr_in;
                  fill_ff <= fill_in;
                  if (fill_in == FB'(WINDOW_CODONS)) begin
                     state_ff <= S_SWEEP;
                     issue_ff <= '0;
                     sact_ff <= '0;
                     smin_ff <= '0;
                     smax_ff <= '0;
                     savg_ff <= '0;
                  end
               end
            end
            S_SWEEP: begin
               if (issue_go) begin
                  issue_ff <= issue_ff + 1'b1;
               end else if (!v1_ff && !v2_ff && !v3_ff) begin
                  state_ff <= S_PICK;
               end
            end
            S_PICK: begin
               an_ff     <= num < 0 ? SB'(-num) : SB'(num);
               ad_ff     <= dsel < 0 ? SB'(-dsel) : SB'(dsel);
               neg_ff    <= (num < 0) != (dsel < 0);
               usemin_ff <= use_min;
               fault_ff  <= (dsel == 0);
               state_ff  <= (dsel == 0) ? S_DONE : S_MULT;
            end
            S_MULT: begin
               quo_ff   <= NB'(an_ff) * NB'(cmmw_pkg::SCALE_X2) + NB'(ad_ff);
               den_ff   <= {1'b0, ad_ff, 1'b0};
               rem_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               quo_ff <= {quo_ff[NB-2:0], ge};
               rem_ff <= ge ? rem_sh - den_ff : rem_sh;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CB'(NB - 1)) state_ff <= S_DONE;
            end
            S_DONE: begin
               if (rsp_free) begin
                  rscore_ff <= fault_ff ? '0 : score_sat;
                  rmin_ff   <= usemin_ff;
                  rfault_ff <= fault_ff;
                  state_ff  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid           = rv_ff;
   assign rsp_chan.percent_minmax  = rscore_ff;
   assign rsp_chan.used_min_branch = rmin_ff;
   assign rsp_chan.divide_fault    = rfault_ff;
endmodule

/* tb/tb_codon_minmax_window_if.sv */
// Testbench note: channel interfaces come from hdl/cmmw_if.sv; this file only
// holds the score predictor class used by the testbench top. Depends on cmmw_pkg.
`timescale 1ns / 1ps

class minmax_scoreboard;
   localparam int WIN = cmmw_pkg::WINDOW_CODONS_DEF;
   // predictor state
   bit [4:0]  codon_class [64];
   bit [15:0] codon_freq [64];
   bit [15:0] aa_min [32], aa_max [32], aa_avg [32];
   bit [5:0]  ring [WIN];
   int        ring_ptr, fill;
   // pending scores: {score, min branch, fault}
   bit [17:0] pending_scores[$];
   int        mismatches;

   function new();
      ring_ptr = 0; fill = 0; mismatches = 0;
      foreach (ring[k]) ring[k] = 0;
   endfunction

   function bit [17:0] score_window();
      longint sa, sv, sx, sn, num, dmax, dmin, dv, an, ad, q;
      bit use_min, neg;
      bit signed [15:0] sc;
      bit [4:0] aa;
      sa = 0; sv = 0; sx = 0; sn = 0; sc = 0;
      for (int k = 0; k < WIN; k++) begin
         aa = codon_class[ring[k]];
         sa += codon_freq[ring[k]];
         sn += aa_min[aa]; sx += aa_max[aa]; sv += aa_avg[aa];
      end
      num = sa - sv; dmax = sx - sv; dmin = sv - sn;
      use_min = (num < 0 && dmax >= 0) || (num > 0 && dmax < 0);
      dv = use_min ? dmin : dmax;
      if (dv == 0) return {16'sd0, use_min, 1'b1};
      neg = (num < 0) != (dv < 0);
      an = num < 0 ? -num : num;
      ad = dv < 0 ? -dv : dv;
      q = (2 * an * 25600 + ad) / (2 * ad);
      if (neg) sc = q > 32768 ? -16'sd32768 : 16'(-q);
      else sc = q > 32767 ? 16'sd32767 : 16'(q);
      return {sc, use_min, 1'b0};
   endfunction

   // note one accepted input beat
   function void note_item(bit [1:0] op, bit [5:0] idx, bit [4:0] cls, bit [15:0] cf,
                           bit [15:0] mn, bit [15:0] mx, bit [15:0] av, bit start);
      case (op)
         cmmw_pkg::OP_LOAD_CODON: begin
            codon_class[idx] = cls; codon_freq[idx] = cf;
         end
         cmmw_pkg::OP_LOAD_AA: if (idx < 32) begin
            aa_min[idx] = mn; aa_max[idx] = mx; aa_avg[idx] = av;
         end
         cmmw_pkg::OP_STREAM: begin
            if (start) begin
               ring_ptr = 0; fill = 0;
               foreach (ring[k]) ring[k] = 0;
            end
            ring[ring_ptr] = idx;
            ring_ptr = (ring_ptr + 1 >= WIN) ? 0 : ring_ptr + 1;
            if (fill < WIN) fill++;
            if (fill == WIN) pending_scores = {pending_scores, score_window()};
         end
         default: ;
      endcase
   endfunction

   // check one result beat against the oldest pending score
   function void check_result(bit [15:0] sc, bit mb, bit df);
      bit [17:0] exp_v;
      if (pending_scores.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result beat score=%0d", $signed(sc));
         return;
      end
      exp_v = pending_scores.pop_front();
      if (exp_v != {sc, mb, df}) begin
         mismatches++;
         if (mismatches <= 10)
            $display("score mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
                     $signed(exp_v[17:2]), exp_v[1], exp_v[0], $signed(sc), mb, df);
      end
   endfunction
endclass

/* tb/tb_codon_minmax_window_top.sv */
// Testbench top for codon_minmax_window_top: directed and random table loads
// and codon streams, scored by minmax_scoreboard. Depends on cmmw_pkg, cmmw_if.
`timescale 1ns / 1ps

module tb_codon_minmax_window_top;
   logic clock = 0;
   logic reset = 1;
   cmmw_req_if req_chan();
   cmmw_rsp_if rsp_chan();

   codon_minmax_window_top u_top (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   minmax_scoreboard scores = new();
   longint cycles = 0;
   bit     no_idle = 0;

   initial forever #5 clock = ~clock;

   initial begin
      req_chan.valid = 0; req_chan.op = '0; req_chan.index = '0;
      req_chan.amino_acid = '0; req_chan.codon_frequency = '0;
      req_chan.aa_minimum = '0; req_chan.aa_maximum = '0;
      req_chan.aa_average = '0; req_chan.sequence_start = 0;
      rsp_chan.ready = 0;
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 1000000) begin
         $display("tb_codon_minmax_window_top: done, errors");
         $finish;
      end
   end

   // sink side: random stall, check every accepted beat
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         scores.check_result(rsp_chan.percent_minmax, rsp_chan.used_min_branch,
                             rsp_chan.divide_fault);
      rsp_chan.ready <= no_idle || ($urandom_range(99) >= 29);
   end

   // one request beat, with random idling ahead of it
   task automatic send(bit [1:0] op, bit [5:0] idx, bit [4:0] cls, bit [15:0] cf,
                       bit [15:0] mn, bit [15:0] mx, bit [15:0] av, bit start);
      while (!no_idle && $urandom_range(99) < 29) begin
         req_chan.valid <= 0;
         @(posedge clock);
      end
      req_chan.valid <= 1; req_chan.op <= op; req_chan.index <= idx;
      req_chan.amino_acid <= cls; req_chan.codon_frequency <= cf;
      req_chan.aa_minimum <= mn; req_chan.aa_maximum <= mx;
      req_chan.aa_average <= av; req_chan.sequence_start <= start;
      do @(posedge clock); while (!req_chan.ready);
      scores.note_item(op, idx, cls, cf, mn, mx, av, start);
   endtask

   task automatic load_codon(bit [5:0] idx, bit [4:0] cls, bit [15:0] cf);
      send(cmmw_pkg::OP_LOAD_CODON, idx, cls, cf, 16'($urandom), 16'($urandom),
           16'($urandom), 1'($urandom));
   endtask

   task automatic load_aa(bit [5:0] idx, bit [15:0] mn, bit [15:0] mx, bit [15:0] av);
      send(cmmw_pkg::OP_LOAD_AA, idx, 5'($urandom), 16'($urandom), mn, mx, av,
           1'($urandom));
   endtask

   task automatic stream(bit [5:0] idx, bit start);
      send(cmmw_pkg::OP_STREAM, idx, 5'($urandom), 16'($urandom), 16'($urandom),
           16'($urandom), 16'($urandom), start);
   endtask

   function automatic bit [15:0] rand_freq();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(16));
         default: return 16'($urandom);
      endcase
   endfunction

   // drop valid, then wait for every expected score
   task automatic wait_drained();
      req_chan.valid <= 0;
      while (scores.pending_scores.size() != 0) @(posedge clock);
   endtask

   initial begin
      int n;
      bit [15:0] base;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: fill every table entry; ignored ops and out-of-range loads
      for (int k = 0; k < 64; k++)
         load_codon(6'(k), 5'(k % 32), (k == 0) ? 16'h0 : 16'(16'hFFFF - k));
      for (int k = 0; k < 32; k++)
         load_aa(6'(k), 16'(16'h0100 * (k % 4)), 16'hFFFF, 16'h8000);
      load_aa(6'd40, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send(cmmw_pkg::OP_RESERVED, 6'd63, 5'd31, 16'hFFFF, 16'hFFFF, 16'hFFFF,
           16'hFFFF, 1);
      // one codon repeated over a full window: max branch, nonzero divisor
      for (int k = 0; k < 18; k++) stream(6'd5, k == 0);
      // mid-window reload, extreme maxima
      load_aa(6'd5, 16'hFFFF, 16'h0, 16'h0);
      stream(6'd63, 0);
      stream(6'd0, 1);

      // pause until every score is out
      wait_drained();

      // random part; a long stretch without idling in the middle
      n = 0;
      while (n < 1800) begin
         no_idle = (n >= 700 && n < 1000);
         case ($urandom_range(19))
            0: begin load_codon(6'($urandom), 5'($urandom), rand_freq()); n++; end
            1: begin
               base = rand_freq();
               load_aa(6'($urandom_range(63)), $urandom_range(3) == 0 ? base : rand_freq(),
                       rand_freq(), base);
               n++;
            end
            2: if ($urandom_range(9) == 0)
                  send(cmmw_pkg::OP_RESERVED, 6'($urandom), 5'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
            default: begin
               stream(6'($urandom), $urandom_range(60) == 0);
               n++;
            end
         endcase
      end
      no_idle = 0;

      // drain, then keep checking for unexpected result beats before the verdict
      wait_drained();
      repeat (200) @(posedge clock);
      if (scores.mismatches == 0 && scores.pending_scores.size() == 0)
         $display("tb_codon_minmax_window_top: done, clean");
      else
         $display("tb_codon_minmax_window_top: done, errors");
      $finish;
   end
endmodule
